@@ sv/dsmb_pkg.sv @@
// Shared definitions for the dual-side mailbox: request codes, register map,
// FIFO sizing and the register-access struct.
// No dependencies; used by dsmb_regs and dual_side_mailbox_fifo.
package dsmb_pkg;

    localparam int unsigned FIFO_DEPTH = 32;
    // Positions run from 0 up to FIFO_DEPTH inclusive.
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int unsigned QUAD_W     = 128;

    typedef enum logic [2:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_PUSH  = 3'd2,
        REQ_POP   = 3'd3,
        REQ_RESET = 3'd4
    } t_req;

    // Sub-side window.
    localparam logic [31:0] SUB_CMD_M2S   = 32'h1d00_0000;
    localparam logic [31:0] SUB_CMD_S2M   = 32'h1d00_0010;
    localparam logic [31:0] SUB_FLAG_M2S  = 32'h1d00_0020;
    localparam logic [31:0] SUB_FLAG_S2M  = 32'h1d00_0030;
    localparam logic [31:0] SUB_CTRL      = 32'h1d00_0040;
    localparam logic [31:0] SUB_BELL      = 32'h1d00_0060;
    // Main-side window.
    localparam logic [31:0] MAIN_CMD_M2S  = 32'h1000_f200;
    localparam logic [31:0] MAIN_CMD_S2M  = 32'h1000_f210;
    localparam logic [31:0] MAIN_FLAG_M2S = 32'h1000_f220;
    localparam logic [31:0] MAIN_FLAG_S2M = 32'h1000_f230;
    localparam logic [31:0] MAIN_CTRL     = 32'h1000_f240;
    localparam logic [31:0] MAIN_BELL     = 32'h1000_f260;

    localparam logic [31:0] CTRL_RESET    = 32'hf000_0012;
    localparam logic [31:0] SUB_CTRL_OR   = 32'hf000_0001;
    localparam logic [31:0] MAIN_CTRL_OR  = 32'hf000_0101;

    typedef struct packed {
        logic        wr_en;
        logic [31:0] addr;
        logic [31:0] data;
    } t_reg_req;

endpackage

@@ sv/dual_side_mailbox_fifo.sv @@
// An accepted request beat is held in the first stage and then moves to the output
// register, from which the master side takes its result beat; a stalled output holds both.
// Throughput: one request per cycle, sustained, as long as the result side takes beats;
// the FIFO memory has one write port and one read port.
// Reset (i_rst_n low, synchronous): registers return to their reset values, both FIFO
// positions go to zero and the pipeline empties; the FIFO memory itself is not cleared.
module dual_side_mailbox_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, from bit 0: addr[31:0], reg_data[63:32], push_lo[127:64], push_hi[191:128]
    input  logic [191:0] s_axis_tdata,
    // tuser, from bit 0: req_type[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, from bit 0: read_data[31:0], pop_lo[95:32], pop_hi[159:96],
    // fifo_empty[160], push_dropped[161], zero fill[167:162]
    output logic [167:0] m_axis_tdata
);

    // The first stage holds everything decided at acceptance; the memory read data
    // is registered alongside it at acceptance.
    typedef struct packed {
        logic [31:0] read_data;
        logic        pop_hit;
        logic        empty;
        logic        dropped;
    } t_s1;

    logic                          in_acc;
    logic                          s1_adv;
    dsmb_pkg::t_req                req;
    logic [31:0]                   in_addr;
    logic [31:0]                   in_wdata;
    logic [dsmb_pkg::QUAD_W-1:0]   in_quad;

    logic [dsmb_pkg::PTR_W-1:0]    r_rd_pos;
    logic [dsmb_pkg::PTR_W-1:0]    r_wr_pos;
    logic [dsmb_pkg::PTR_W-1:0]    n_rd_pos;
    logic [dsmb_pkg::PTR_W-1:0]    n_wr_pos;
    logic [dsmb_pkg::PTR_W-1:0]    prev_pos;

    logic                          mem_wr_en;
    logic                          mem_rd_en;
    logic [dsmb_pkg::ADDR_W-1:0]   mem_rd_addr;
    logic [dsmb_pkg::QUAD_W-1:0]   r_mem [dsmb_pkg::FIFO_DEPTH];
    logic [dsmb_pkg::QUAD_W-1:0]   r_rdata;

    dsmb_pkg::t_reg_req            reg_req;
    logic [31:0]                   reg_rd_data;

    t_s1                           n_s1;
    t_s1                           r_s1;
    logic                          r_s1_valid;
    logic                          r_o_valid;
    logic [167:0]                  r_o_tdata;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign req      = dsmb_pkg::t_req'(s_axis_tuser);
    assign in_addr  = s_axis_tdata[31:0];
    assign in_wdata = s_axis_tdata[63:32];
    assign in_quad  = s_axis_tdata[191:64];

    // The first stage moves on when the output register is free or being drained.
    assign s1_adv        = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || !r_o_valid || m_axis_tready;

    assign reg_req.wr_en = in_acc && (req == dsmb_pkg::REQ_WRITE);
    assign reg_req.addr  = in_addr;
    assign reg_req.data  = in_wdata;

    dsmb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (reg_req),
        .o_rd_data (reg_rd_data)
    );

    assign prev_pos = r_rd_pos - dsmb_pkg::PTR_W'(1);

    // Request decode. All FIFO state lives in the positions and the memory; a pop reads the
    // head, or on an empty FIFO with a nonzero read position re-reads the entry taken last.
    always_comb begin
        n_rd_pos          = r_rd_pos;
        n_wr_pos          = r_wr_pos;
        mem_wr_en         = 1'b0;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = r_rd_pos[dsmb_pkg::ADDR_W-1:0];
        n_s1.read_data    = '0;
        n_s1.pop_hit      = 1'b0;
        n_s1.dropped      = 1'b0;
        case (req)
            dsmb_pkg::REQ_READ: begin
                n_s1.read_data = reg_rd_data;
            end
            dsmb_pkg::REQ_PUSH: begin
                if (r_wr_pos == dsmb_pkg::PTR_W'(dsmb_pkg::FIFO_DEPTH)) begin
                    n_s1.dropped = 1'b1;
                end else begin
                    mem_wr_en = in_acc;
                    n_wr_pos  = r_wr_pos + dsmb_pkg::PTR_W'(1);
                end
            end
            dsmb_pkg::REQ_POP: begin
                if (r_rd_pos != r_wr_pos) begin
                    mem_rd_en    = in_acc;
                    n_s1.pop_hit = 1'b1;
                    n_rd_pos     = r_rd_pos + dsmb_pkg::PTR_W'(1);
                end else if (r_rd_pos != '0) begin
                    mem_rd_en    = in_acc;
                    mem_rd_addr  = prev_pos[dsmb_pkg::ADDR_W-1:0];
                    n_s1.pop_hit = 1'b1;
                end
            end
            dsmb_pkg::REQ_RESET: begin
                n_rd_pos = '0;
                n_wr_pos = '0;
            end
            default: ;
        endcase
        n_s1.empty = (n_rd_pos == n_wr_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
            r_wr_pos <= '0;
        end else if (in_acc) begin
            r_rd_pos <= n_rd_pos;
            r_wr_pos <= n_wr_pos;
        end
    end

    // Quadword store. A push and a pop never share a beat, and a read always
    // comes on a later beat than any earlier write, so no bypass is needed.
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[r_wr_pos[dsmb_pkg::ADDR_W-1:0]] <= in_quad;
        end
    end

    // Read data holds while the first stage is stalled: no new read is issued then.
    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_rdata <= r_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_tdata <= {6'd0, r_s1.dropped, r_s1.empty,
                          (r_s1.pop_hit ? r_rdata : {dsmb_pkg::QUAD_W{1'b0}}),
                          r_s1.read_data};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_tdata;

`ifndef SYNTHESIS
    a_wr_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pos <= dsmb_pkg::PTR_W'(dsmb_pkg::FIFO_DEPTH))
        else $error("write position beyond FIFO depth");

    a_rd_le_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pos <= r_wr_pos)
        else $error("read position passed write position");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (req == dsmb_pkg::REQ_PUSH)
            && (r_wr_pos == dsmb_pkg::PTR_W'(dsmb_pkg::FIFO_DEPTH))
        |=> r_s1.dropped && $stable(r_wr_pos))
        else $error("push on full FIFO not flagged as dropped");

    a_fifo_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (req == dsmb_pkg::REQ_RESET)
        |=> (r_rd_pos == '0) && (r_wr_pos == '0) && r_s1.empty)
        else $error("FIFO reset did not clear positions");

    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1.pop_hit && !s1_adv |=> $stable(r_rdata))
        else $error("memory read data changed under a stall");
`endif

endmodule

@@ sv/dsmb_regs.sv @@
// Mailbox register file: command, flag, control and doorbell words with
// per-side address decode. Depends on dsmb_pkg.
module dsmb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dsmb_pkg::t_reg_req i_req,
    output logic [31:0]        o_rd_data
);

    logic [31:0] r_cmd_m2s;
    logic [31:0] r_cmd_s2m;
    logic [31:0] r_flag_m2s;
    logic [31:0] r_flag_s2m;
    logic [31:0] r_ctrl;
    logic [31:0] r_bell;

    // Read decode uses the values held before this beat's write.
    always_comb begin
        case (i_req.addr)
            dsmb_pkg::SUB_CMD_M2S, dsmb_pkg::MAIN_CMD_M2S:   o_rd_data = r_cmd_m2s;
            dsmb_pkg::SUB_CMD_S2M, dsmb_pkg::MAIN_CMD_S2M:   o_rd_data = r_cmd_s2m;
            dsmb_pkg::SUB_FLAG_M2S, dsmb_pkg::MAIN_FLAG_M2S: o_rd_data = r_flag_m2s;
            dsmb_pkg::SUB_FLAG_S2M, dsmb_pkg::MAIN_FLAG_S2M: o_rd_data = r_flag_s2m;
            dsmb_pkg::SUB_CTRL:  o_rd_data = r_ctrl | dsmb_pkg::SUB_CTRL_OR;
            dsmb_pkg::MAIN_CTRL: o_rd_data = r_ctrl | dsmb_pkg::MAIN_CTRL_OR;
            dsmb_pkg::SUB_BELL, dsmb_pkg::MAIN_BELL:         o_rd_data = r_bell;
            default:                                         o_rd_data = '0;
        endcase
    end

    // The sending side sets flag bits, the receiving side clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_m2s  <= '0;
            r_cmd_s2m  <= '0;
            r_flag_m2s <= '0;
            r_flag_s2m <= '0;
            r_ctrl     <= dsmb_pkg::CTRL_RESET;
            r_bell     <= '0;
        end else if (i_req.wr_en) begin
            case (i_req.addr)
                dsmb_pkg::SUB_CMD_M2S, dsmb_pkg::MAIN_CMD_M2S: r_cmd_m2s <= i_req.data;
                dsmb_pkg::SUB_CMD_S2M, dsmb_pkg::MAIN_CMD_S2M: r_cmd_s2m <= i_req.data;
                dsmb_pkg::SUB_FLAG_M2S:  r_flag_m2s <= r_flag_m2s & ~i_req.data;
                dsmb_pkg::MAIN_FLAG_M2S: r_flag_m2s <= r_flag_m2s | i_req.data;
                dsmb_pkg::SUB_FLAG_S2M:  r_flag_s2m <= r_flag_s2m | i_req.data;
                dsmb_pkg::MAIN_FLAG_S2M: r_flag_s2m <= r_flag_s2m & ~i_req.data;
                dsmb_pkg::SUB_CTRL, dsmb_pkg::MAIN_CTRL:       r_ctrl <= i_req.data;
                dsmb_pkg::SUB_BELL, dsmb_pkg::MAIN_BELL:       r_bell <= i_req.data;
                default: ;
            endcase
        end
    end

endmodule
